### rtl/mdc_pkg.sv
// Shared widths, reset values, register indexes and item/result types
// for the microphone DC-block, gain and statistics core. No dependencies.
package mdc_pkg;

   localparam int COUNT_BITS     = 24;
   localparam int FRACTION_BITS  = 16;
   localparam int STATE_BITS     = 34;
   localparam int SUM_BITS       = 55;
   localparam int COEF_BITS      = 15;
   localparam int GAIN_BITS      = 4;
   localparam int PCM_BITS       = 16;
   localparam int SLOT_BITS      = 32;
   localparam int CAPTURE_BITS   = 24;
   localparam int DATA_BITS      = 32;
   localparam int ADDR_BITS      = 3;
   localparam int REG_INDEX_BITS = 1;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

   localparam int ROOT_BITS      = (SUM_BITS + 1) / 2;
   localparam int RAD_BITS       = 2 * ROOT_BITS;
   localparam int STEP_BITS      = $clog2(SUM_BITS + 1);

   localparam logic [COEF_BITS-1:0] COEF_RESET = COEF_BITS'(32604);
   localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(5);
   localparam int                   RMS_MAX    = 32768;

   localparam logic [REG_INDEX_BITS-1:0] REG_COEF = 1'd0;
   localparam logic [REG_INDEX_BITS-1:0] REG_GAIN = 1'd1;

   typedef struct packed {
      logic signed [PCM_BITS-1:0] sample;
      logic                       first;
      logic                       last;
   } item_type;

   typedef struct packed {
      logic [COEF_BITS-1:0] coef;
      logic [GAIN_BITS-1:0] gain;
   } cfg_type;

   typedef struct packed {
      logic signed [PCM_BITS-1:0] pcm_sample;
      logic                       stats_valid;
      logic [PCM_BITS-1:0]        peak_magnitude;
      logic [PCM_BITS-1:0]        rms_level;
      logic [CAPTURE_BITS-1:0]    capture_count;
   } result_type;

endpackage

### rtl/mic_dc_block_gain_stats_core.sv
// Microphone DC-block, gain and statistics core: register file, front stage,
// item queue and back sequencer. Depends on mdc_pkg, mdc_front, mdc_queue, mdc_back.
// Sequencing: the back sequencer takes a new item only from idle, then steps through filter,
// gain and statistics (waiting for a free output register on an ordinary item); a last item
// adds a divide (one quotient bit a cycle), a root (one bit a cycle) and an emit step.
// Reset: synchronous; clears filter and statistics state, registers to defaults.
module mic_dc_block_gain_stats_core import mdc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SLOT_BITS-1:0] req_raw_slot,
   input  logic                       req_first_sample,
   input  logic                       req_last_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [PCM_BITS-1:0] rsp_pcm_sample,
   output logic                       rsp_stats_valid,
   output logic [PCM_BITS-1:0]        rsp_peak_magnitude,
   output logic [PCM_BITS-1:0]        rsp_rms_level,
   output logic [CAPTURE_BITS-1:0]    rsp_capture_count,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [ADDR_BITS-1:0]       paddr,
   input  logic [DATA_BITS-1:0]       pwdata,
   output logic [DATA_BITS-1:0]       prdata,
   output logic                       pready
);

   logic [COEF_BITS-1:0]      coef_ff, coef_in;
   logic [GAIN_BITS-1:0]      gain_ff, gain_in;
   logic [REG_INDEX_BITS-1:0] reg_index;
   logic                      csr_write;
   cfg_type                   cfg;
   logic                      fq_valid, fq_ready, qb_valid, qb_ready;
   item_type                  fq_item, qb_item;
   result_type                result;

   assign pready    = 1'b1;
   assign reg_index = paddr[ADDR_BITS-1 -: REG_INDEX_BITS];
   assign csr_write = psel && penable && pwrite && pready;
   assign cfg.coef  = coef_ff;
   assign cfg.gain  = gain_ff;

   always_comb begin
      coef_in = coef_ff;
      gain_in = gain_ff;
      prdata  = '0;
      unique case (reg_index)
         REG_COEF: begin
            prdata = DATA_BITS'(coef_ff);
            if (csr_write) begin
               coef_in = pwdata[COEF_BITS-1:0];
            end
         end
         REG_GAIN: begin
            prdata = DATA_BITS'(gain_ff);
            if (csr_write) begin
               gain_in = pwdata[GAIN_BITS-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
         gain_ff <= GAIN_RESET;
      end else begin
         coef_ff <= coef_in;
         gain_ff <= gain_in;
      end
   end

   mdc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .raw_slot     (req_raw_slot),
      .first_sample (req_first_sample),
      .last_sample  (req_last_sample),
      .out_valid    (fq_valid),
      .out_ready    (fq_ready),
      .out_item     (fq_item)
   );

   mdc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_item  (fq_item),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_item   (qb_item)
   );

   mdc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (qb_valid),
      .in_ready   (qb_ready),
      .in_item    (qb_item),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (result)
   );

   assign rsp_pcm_sample     = result.pcm_sample;
   assign rsp_stats_valid    = result.stats_valid;
   assign rsp_peak_magnitude = result.peak_magnitude;
   assign rsp_rms_level      = result.rms_level;
   assign rsp_capture_count  = result.capture_count;

   a_plain_result_no_stats: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stats_valid |->
      rsp_peak_magnitude == '0 && rsp_rms_level == '0 && rsp_capture_count == '0)
      else $error("statistics fields set on an ordinary transaction");

   a_stats_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stats_valid |->
      rsp_rms_level <= PCM_BITS'(RMS_MAX) && rsp_peak_magnitude <= PCM_BITS'(RMS_MAX) &&
      rsp_capture_count != '0)
      else $error("statistics out of range");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid && !qb_valid)
      else $error("queue or response not empty after reset");

endmodule

### rtl/mdc_front.sv
// Front stage: takes request transactions, extracts the upper slot half as the
// sample and holds the classified item for the queue. Depends on mdc_pkg.
module mdc_front import mdc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [SLOT_BITS-1:0] raw_slot,
   input  logic                 first_sample,
   input  logic                 last_sample,
   output logic                 out_valid,
   input  logic                 out_ready,
   output item_type             out_item
);

   logic     hold_ff, hold_in;
   item_type item_ff, item_in;
   logic     take;

   assign in_ready  = !hold_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = hold_ff;
   assign out_item  = item_ff;

   always_comb begin
      item_in = item_ff;
      hold_in = hold_ff;
      if (take) begin
         item_in.sample = $signed(raw_slot[SLOT_BITS-1 -: PCM_BITS]);
         item_in.first  = first_sample;
         item_in.last   = last_sample;
         hold_in        = 1'b1;
      end else if (out_ready) begin
         hold_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else begin
         hold_ff <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

### rtl/mdc_queue.sv
// Short FIFO of classified items between the front stage and the back
// sequencer. Depends on mdc_pkg.
module mdc_queue import mdc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;
   logic                 push, pop;

   assign push_ready = (count_ff != (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/mdc_back.sv
// Back sequencer: filter, gain, statistics, then restoring divide and
// digit-by-digit square root on a last item; owns the result register.
// Depends on mdc_pkg.
module mdc_back import mdc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       in_valid,
   output logic       in_ready,
   input  item_type   in_item,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   localparam int PROD_BITS  = STATE_BITS + COEF_BITS + 1;
   localparam int DIFF_BITS  = PCM_BITS + 1 + FRACTION_BITS;
   localparam int SPROD_BITS = PROD_BITS - COEF_BITS;
   localparam int FILT_BITS  = ((DIFF_BITS > SPROD_BITS) ? DIFF_BITS : SPROD_BITS) + 1;
   localparam int GPROD_BITS = STATE_BITS + GAIN_BITS + 1;
   localparam int SREM_BITS  = ROOT_BITS + 1;
   localparam logic [STEP_BITS-1:0] DIV_LAST  = STEP_BITS'(SUM_BITS - 1);
   localparam logic [STEP_BITS-1:0] SQRT_LAST = STEP_BITS'(ROOT_BITS - 1);
   localparam logic [ROOT_BITS-1:0] RMS_LIMIT = ROOT_BITS'(RMS_MAX);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_FILT = 3'd1;
   localparam logic [2:0] ST_GAIN = 3'd2;
   localparam logic [2:0] ST_STAT = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_SQRT = 3'd5;
   localparam logic [2:0] ST_EMIT = 3'd6;

   logic [2:0]                   state_ff, state_in;
   logic                         out_valid_ff, out_valid_in;
   result_type                   out_ff, out_in;
   logic signed [PCM_BITS-1:0]   x_ff, x_in;
   logic                         last_ff, last_in;
   logic signed [PROD_BITS-1:0]  prod_ff, prod_in;
   logic signed [STATE_BITS-1:0] y_ff, y_in;
   logic signed [PCM_BITS-1:0]   pcm_ff, pcm_in;
   logic signed [PCM_BITS-1:0]   prev_in_ff, prev_in_in;
   logic signed [STATE_BITS-1:0] prev_out_ff, prev_out_in;
   logic [PCM_BITS-1:0]          peak_ff, peak_in;
   logic [SUM_BITS-1:0]          sum_ff, sum_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic [STEP_BITS-1:0]         step_ff, step_in;
   logic [COUNT_BITS-1:0]        rem_ff, rem_in;
   logic [SUM_BITS-1:0]          quot_ff, quot_in;
   logic [RAD_BITS-1:0]          rad_ff, rad_in;
   logic [ROOT_BITS-1:0]         root_ff, root_in;
   logic [SREM_BITS-1:0]         srem_ff, srem_in;

   logic                          out_free;
   logic signed [PCM_BITS:0]      diff;
   logic signed [PROD_BITS-1:0]   prod_shift;
   logic signed [FILT_BITS-1:0]   filt;
   logic signed [GPROD_BITS-1:0]  gprod, gadj, gshift;
   logic [PCM_BITS-1:0]           mag;
   logic [2*PCM_BITS-1:0]         square;
   logic [SUM_BITS:0]             sum_ext;
   logic [COUNT_BITS:0]           dtrial;
   logic                          qbit;
   logic [SREM_BITS+1:0]          scand, strial;

   assign in_ready   = (state_ff == ST_IDLE);
   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;
   assign out_free   = !out_valid_ff || out_ready;

   always_comb begin
      diff       = $signed({x_ff[PCM_BITS-1], x_ff})
                 - $signed({prev_in_ff[PCM_BITS-1], prev_in_ff});
      prod_shift = prod_ff >>> COEF_BITS;
      filt       = (FILT_BITS'(diff) <<< FRACTION_BITS) + FILT_BITS'(prod_shift);

      gprod  = GPROD_BITS'(y_ff) * GPROD_BITS'($signed({1'b0, cfg.gain}));
      gadj   = gprod + (gprod[GPROD_BITS-1] ?
               {{(GPROD_BITS-FRACTION_BITS){1'b0}}, {FRACTION_BITS{1'b1}}} :
               {GPROD_BITS{1'b0}});
      gshift = gadj >>> FRACTION_BITS;

      mag     = pcm_ff[PCM_BITS-1] ? $unsigned(~pcm_ff) + 1'b1 : $unsigned(pcm_ff);
      square  = (2*PCM_BITS)'(mag) * (2*PCM_BITS)'(mag);
      sum_ext = {1'b0, sum_ff} + (SUM_BITS+1)'(square);

      dtrial = {rem_ff, quot_ff[SUM_BITS-1]};
      qbit   = (dtrial >= {1'b0, count_ff});

      scand  = {srem_ff, rad_ff[RAD_BITS-1 -: 2]};
      strial = {1'b0, root_ff, 2'b01};
   end

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      x_in         = x_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      y_in         = y_ff;
      pcm_in       = pcm_ff;
      prev_in_in   = prev_in_ff;
      prev_out_in  = prev_out_ff;
      peak_in      = peak_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      srem_in      = srem_ff;

      if (out_ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               x_in    = in_item.sample;
               last_in = in_item.last;
               if (in_item.first) begin
                  prev_in_in  = '0;
                  prev_out_in = '0;
                  peak_in     = '0;
                  sum_in      = '0;
                  count_in    = '0;
                  prod_in     = '0;
               end else begin
                  prod_in = PROD_BITS'($signed({1'b0, cfg.coef})) * PROD_BITS'(prev_out_ff);
               end
               state_in = ST_FILT;
            end
         end
         ST_FILT: begin
            if (filt[FILT_BITS-1:STATE_BITS-1] == '0 ||
                filt[FILT_BITS-1:STATE_BITS-1] == '1) begin
               y_in = filt[STATE_BITS-1:0];
            end else if (filt[FILT_BITS-1]) begin
               y_in = {1'b1, {(STATE_BITS-1){1'b0}}};
            end else begin
               y_in = {1'b0, {(STATE_BITS-1){1'b1}}};
            end
            prev_in_in  = x_ff;
            prev_out_in = y_in;
            state_in    = ST_GAIN;
         end
         ST_GAIN: begin
            if (gshift[GPROD_BITS-1:PCM_BITS-1] == '0 ||
                gshift[GPROD_BITS-1:PCM_BITS-1] == '1) begin
               pcm_in = gshift[PCM_BITS-1:0];
            end else if (gshift[GPROD_BITS-1]) begin
               pcm_in = {1'b1, {(PCM_BITS-1){1'b0}}};
            end else begin
               pcm_in = {1'b0, {(PCM_BITS-1){1'b1}}};
            end
            state_in = ST_STAT;
         end
         ST_STAT: begin
            if (last_ff || out_free) begin
               if (mag > peak_ff) begin
                  peak_in = mag;
               end
               sum_in = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
               if (count_ff != '1) begin
                  count_in = count_ff + 1'b1;
               end
               if (last_ff) begin
                  rem_in   = '0;
                  quot_in  = sum_in;
                  step_in  = DIV_LAST;
                  state_in = ST_DIV;
               end else begin
                  out_valid_in          = 1'b1;
                  out_in.pcm_sample     = pcm_ff;
                  out_in.stats_valid    = 1'b0;
                  out_in.peak_magnitude = '0;
                  out_in.rms_level      = '0;
                  out_in.capture_count  = '0;
                  state_in              = ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            rem_in  = qbit ? COUNT_BITS'(dtrial - {1'b0, count_ff}) : dtrial[COUNT_BITS-1:0];
            quot_in = {quot_ff[SUM_BITS-2:0], qbit};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               rad_in   = (count_ff == '0) ? '0 : RAD_BITS'(quot_in);
               root_in  = '0;
               srem_in  = '0;
               step_in  = SQRT_LAST;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (scand >= strial) begin
               srem_in = SREM_BITS'(scand - strial);
               root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
            end else begin
               srem_in = scand[SREM_BITS-1:0];
               root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
            end
            rad_in  = {rad_ff[RAD_BITS-3:0], 2'b00};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in          = 1'b1;
               out_in.pcm_sample     = pcm_ff;
               out_in.stats_valid    = 1'b1;
               out_in.peak_magnitude = peak_ff;
               out_in.rms_level      = (root_ff > RMS_LIMIT) ? PCM_BITS'(RMS_LIMIT) :
                                                               root_ff[PCM_BITS-1:0];
               out_in.capture_count  = CAPTURE_BITS'(count_ff);
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         prev_in_ff   <= '0;
         prev_out_ff  <= '0;
         peak_ff      <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         prev_in_ff   <= prev_in_in;
         prev_out_ff  <= prev_out_in;
         peak_ff      <= peak_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      x_ff    <= x_in;
      last_ff <= last_in;
      prod_ff <= prod_in;
      y_ff    <= y_in;
      pcm_ff  <= pcm_in;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
      srem_ff <= srem_in;
   end

endmodule
